[sv/brf_pkg.sv]
// Shared types and constants for the bitmap rectangle fill block.
package brf_pkg;

  localparam int MAX_ROW_BYTES = 32;
  localparam int MAX_ROWS      = 256;
  localparam int STORE_BYTES   = MAX_ROW_BYTES * MAX_ROWS;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int COL_W         = $clog2(MAX_ROW_BYTES);

  // register index on the configuration port
  localparam logic CFG_ROW_BYTES = 1'b0;
  localparam logic CFG_ROW_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [12:0] byte_address;
    logic [7:0]  byte_data;
    logic [7:0]  left_x;
    logic [7:0]  top_y;
    logic [8:0]  rect_width;
    logic [8:0]  rect_height;
    logic        fill_bit;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       status;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic exec;
    logic fill_rd;
    logic fill_wr;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_fill;
    logic fill_go;
    logic fill_last;
  } sts_t;

endpackage

[sv/brf_ctrl.sv]
// Sequencer for byte access, rectangle fill and the clearing sweep.
module brf_ctrl import brf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.is_fill && sts_i.fill_go) state_d = ST_FILL_RD;
        else state_d = ST_FINISH;
      end
      ST_FILL_RD: begin
        state_d = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        if (sts_i.fill_last) state_d = ST_FINISH;
        else state_d = ST_FILL_RD;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == ST_IDLE) && start;
    cmd_o.clr     = (state_q == ST_CLEAR);
    cmd_o.exec    = (state_q == ST_EXEC);
    cmd_o.fill_rd = (state_q == ST_FILL_RD);
    cmd_o.fill_wr = (state_q == ST_FILL_WR);
    cmd_o.finish  = (state_q == ST_FINISH);
    busy          = (state_q != ST_IDLE);
    done_d        = (state_q == ST_FINISH);
  end

  assign done_o = done_q;

endmodule

[sv/brf_datapath.sv]
// Configuration registers, pixel memory, fill walker and result register.
module brf_datapath import brf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i,
  input  item_t      item_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output result_t    result_o
);

  logic [5:0]        row_bytes_q;
  logic [8:0]        row_count_q;
  item_t             item_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  logic [7:0]        mem_q [STORE_BYTES];
  logic [7:0]        rdata_q;

  logic              st_q;
  logic [7:0]        x0_q;
  logic [7:0]        x1m1_q;
  logic [7:0]        ylast_q;
  logic [7:0]        row_q;
  logic [COL_W-1:0]  col_q;
  logic [ADDR_W-1:0] base_q;
  result_t           result_q;

  // effective geometry
  logic [5:0]  rb;
  logic [8:0]  rc;
  logic [13:0] limit;
  logic        byte_oob;

  always_comb begin
    if (row_bytes_q == 6'd0) rb = 6'd1;
    else if (row_bytes_q > 6'(MAX_ROW_BYTES)) rb = 6'(MAX_ROW_BYTES);
    else rb = row_bytes_q;
    if (row_count_q == 9'd0) rc = 9'd1;
    else if (row_count_q > 9'(MAX_ROWS)) rc = 9'(MAX_ROWS);
    else rc = row_count_q;
  end

  assign limit    = 14'(rb) * 14'(rc);
  assign byte_oob = {1'b0, item_q.byte_address} >= limit;

  // fill setup: clip the rectangle against the bitmap
  logic [9:0]  x1, y1;
  logic [8:0]  wpix, x1c, y1c, x1m1, ylast;
  logic        x_clip, y_clip, nonempty, fill_st, fill_go;
  logic [13:0] base_init;

  always_comb begin
    wpix     = {rb, 3'b000};
    x1       = 10'(item_q.left_x) + 10'(item_q.rect_width);
    y1       = 10'(item_q.top_y) + 10'(item_q.rect_height);
    x_clip   = x1 > 10'(wpix);
    y_clip   = y1 > 10'(rc);
    x1c      = x_clip ? wpix : x1[8:0];
    y1c      = y_clip ? rc : y1[8:0];
    nonempty = (item_q.rect_width != 9'd0) && (item_q.rect_height != 9'd0);
    fill_st  = nonempty && (x_clip || y_clip);
    fill_go  = nonempty && (9'(item_q.left_x) < x1c) && (9'(item_q.top_y) < y1c);
    x1m1     = x1c - 9'd1;
    ylast    = y1c - 9'd1;
    base_init = 14'(item_q.top_y) * 14'(rb);
  end

  // edge masks for the byte under the walker
  logic       col_first, col_last, fill_last;
  logic [2:0] lo, hi;
  logic [7:0] mask, fill_wdata;

  always_comb begin
    col_first  = col_q == x0_q[7:3];
    col_last   = col_q == x1m1_q[7:3];
    fill_last  = col_last && (row_q == ylast_q);
    lo         = col_first ? x0_q[2:0] : 3'd0;
    hi         = col_last ? x1m1_q[2:0] : 3'd7;
    mask       = (8'hFF >> lo) & (8'hFF << (3'd7 - hi));
    fill_wdata = item_q.fill_bit ? (rdata_q | mask) : (rdata_q & ~mask);
  end

  // memory port
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = base_q + ADDR_W'(col_q);
    mem_wdata = fill_wdata;
    priority if (cmd_i.clr) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_q;
      mem_wdata = 8'h00;
    end else if (cmd_i.exec) begin
      mem_addr  = item_q.byte_address;
      mem_wdata = item_q.byte_data;
      mem_we    = (item_q.kind == KIND_WRITE) && !byte_oob;
      mem_re    = (item_q.kind == KIND_READ);
    end else if (cmd_i.fill_rd) begin
      mem_re = 1'b1;
    end else if (cmd_i.fill_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= 6'(MAX_ROW_BYTES);
      row_count_q <= 9'(MAX_ROWS);
      clr_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROW_BYTES: row_bytes_q <= cfg_data_i[5:0];
          CFG_ROW_COUNT: row_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.exec) begin
      unique case (item_q.kind)
        KIND_WRITE, KIND_READ: st_q <= byte_oob;
        KIND_FILL:             st_q <= fill_st;
        default:               st_q <= 1'b0;
      endcase
      x0_q    <= item_q.left_x;
      x1m1_q  <= x1m1[7:0];
      ylast_q <= ylast[7:0];
      row_q   <= item_q.top_y;
      col_q   <= item_q.left_x[7:3];
      base_q  <= base_init[ADDR_W-1:0];
    end
    if (cmd_i.fill_wr) begin
      if (col_last) begin
        col_q  <= x0_q[7:3];
        row_q  <= row_q + 8'd1;
        base_q <= base_q + ADDR_W'(rb);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
    if (cmd_i.finish) begin
      result_q.read_byte <= ((item_q.kind == KIND_READ) && !st_q) ? rdata_q : 8'h00;
      result_q.status    <= st_q;
    end
  end

  always_comb begin
    sts_o.clr_last  = clr_cnt_q == ADDR_W'(STORE_BYTES - 1);
    sts_o.is_fill   = item_q.kind == KIND_FILL;
    sts_o.fill_go   = fill_go;
    sts_o.fill_last = fill_last;
  end

  assign result_o = result_q;

endmodule

[sv/bitmap_rectangle_fill.sv]
// Top level of the one-bit-per-pixel bitmap with byte access and rectangle fill.
// After reset the block sweeps the 8192-byte pixel memory to zero, one byte per cycle,
// and holds busy high throughout the sweep; configuration writes are taken meanwhile.
// An item is taken when start is high and busy low. A byte write, byte read or unknown
// kind goes through the execute and finish states before the done_o strobe, and a
// new item may be started in the cycle the strobe is shown. A fill reads and then
// writes back, masked, every byte the clipped rectangle touches (rows times bytes
// spanned per row), as the single memory port allows one access at a time. The result
// is on result_o while done_o is high and is held there until the next item finishes.
module bitmap_rectangle_fill import brf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  item_t      item_i,
  output logic       done_o,
  output result_t    result_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  brf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  brf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

[sv/brf_checker.sv]
// Port-level checks for the bitmap rectangle fill block, bound to the top level.
module brf_checker import brf_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  // accepted transaction keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  // strobe lasts a single cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o longer than one cycle");

  // a result comes out only as the block goes idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $fell(busy))
    else $error("done_o outside the end of a transaction");

  // a result that is flagged clipped never carries read data
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status |-> result_o.read_byte == 8'h00)
    else $error("clipped transaction returned data");

endmodule

bind bitmap_rectangle_fill brf_checker u_brf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
